### design/assert_macros.svh
// assertion macros for the tone/noise generator
// no dependencies; included by the top level only
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous reset
`define PSG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under synchronous reset
`define PSG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/psgt_pkg.sv
// types, constants and level functions for the tone/noise generator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package psgt_pkg;

   localparam int NUM_CH      = 4;
   localparam int NUM_TONES   = 3;
   localparam int PERIOD_W    = 10;
   localparam int CNT_W       = 14;
   localparam int LFSR_W      = 16;
   localparam int LEVEL_W     = 11;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [7:0]         ADDR_NOISE_CTRL = 8'h06;
   localparam logic [7:0]         ADDR_PERIOD_HI  = 8'h4E;
   localparam logic [7:0]         ADDR_STEREO     = 8'h4F;
   localparam logic [LFSR_W-1:0]  LFSR_SEED       = 16'h8000;
   localparam logic [LFSR_W-1:0]  TAPS_RESET      = 16'h0009;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 11'd1516;
   localparam logic [3:0]         ATTEN_SILENT    = 4'hF;
   localparam logic [PERIOD_W-1:0] NOISE_P_RATE0  = 10'h010;
   localparam logic [PERIOD_W-1:0] NOISE_P_RATE1  = 10'h020;
   localparam logic [PERIOD_W-1:0] NOISE_P_RATE2  = 10'h040;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_TICK,
      OP_PERIOD_LO,
      OP_PERIOD_HI,
      OP_ATTEN,
      OP_NOISE_CTRL,
      OP_STEREO
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] chan;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   function automatic logic [LEVEL_W-1:0] level_lookup(input logic [3:0] atten);
      logic [LEVEL_W-1:0] v;
      case (atten)
         4'd0:    v = 11'd1516;
         4'd1:    v = 11'd1205;
         4'd2:    v = 11'd957;
         4'd3:    v = 11'd760;
         4'd4:    v = 11'd603;
         4'd5:    v = 11'd479;
         4'd6:    v = 11'd381;
         4'd7:    v = 11'd303;
         4'd8:    v = 11'd240;
         4'd9:    v = 11'd191;
         4'd10:   v = 11'd152;
         4'd11:   v = 11'd120;
         4'd12:   v = 11'd96;
         4'd13:   v = 11'd76;
         4'd14:   v = 11'd60;
         default: v = 11'd0;
      endcase
      return v;
   endfunction

   // average of left and right: full value with both sides on, half with one
   function automatic logic [LEVEL_W-1:0] mix_level(input logic [3:0] atten,
                                                    input logic [1:0] stereo,
                                                    input logic       on);
      logic [LEVEL_W-1:0] v;
      logic [LEVEL_W-1:0] r;
      v = on ? level_lookup(atten) : '0;
      case (stereo)
         2'b11:   r = v;
         2'b10,
         2'b01:   r = v >> 1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### design/psgt_decode.sv
// front end: classifies each request word into an engine command
// depends on psgt_pkg
`timescale 1ns / 1ps

module psgt_decode
   import psgt_pkg::*;
(
   input  logic       mode,
   input  logic [7:0] address,
   input  logic [7:0] data,
   output cmd_type    cmd
);

   always_comb begin
      cmd.chan = address[2:1];
      cmd.data = data;
      if (mode) begin
         cmd.op = OP_TICK;
      end else begin
         case (address) inside
            8'h00, 8'h02, 8'h04:        cmd.op = OP_PERIOD_LO;
            8'h01, 8'h03, 8'h05, 8'h07: cmd.op = OP_ATTEN;
            ADDR_NOISE_CTRL:            cmd.op = OP_NOISE_CTRL;
            ADDR_PERIOD_HI:             cmd.op = OP_PERIOD_HI;
            ADDR_STEREO:                cmd.op = OP_STEREO;
            default:                    cmd.op = OP_NONE;
         endcase
      end
   end

endmodule

### design/psgt_queue.sv
// short command queue between decode and engine, first word visible at the head
// depends on psgt_pkg
`timescale 1ns / 1ps

module psgt_queue
   import psgt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type status
);

   cmd_type           mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = mem[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

### design/psgt_engine.sv
// back end: chip registers, four down counters, lfsr and held output levels
// depends on psgt_pkg; the held levels double as the response register
`timescale 1ns / 1ps

module psgt_engine
   import psgt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [LFSR_W-1:0]   csr_wr_data,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LEVEL_W-1:0]  level [NUM_CH]
);

   logic [LFSR_W-1:0]   taps_ff;
   logic [PERIOD_W-1:0] period_ff  [NUM_TONES];
   logic [PERIOD_W-1:0] period_in  [NUM_TONES];
   logic [3:0]          atten_ff   [NUM_CH];
   logic [3:0]          atten_in   [NUM_CH];
   logic [1:0]          stereo_ff  [NUM_CH];
   logic [1:0]          stereo_in  [NUM_CH];
   logic [CNT_W-1:0]    cnt_ff     [NUM_CH];
   logic [CNT_W-1:0]    cnt_in     [NUM_CH];
   logic                phase_ff   [NUM_CH];
   logic                phase_in   [NUM_CH];
   logic [LEVEL_W-1:0]  held_ff    [NUM_CH];
   logic [LEVEL_W-1:0]  held_in    [NUM_CH];
   logic [LFSR_W-1:0]   lfsr_ff, lfsr_in;
   logic [1:0]          rate_ff, rate_in;
   logic                white_ff, white_in;
   logic [1:0]          latch_ff, latch_in;
   logic                valid_ff, valid_in;

   logic [PERIOD_W-1:0] eff_period [NUM_CH];
   logic                reload     [NUM_CH];
   logic                fb;
   logic [LFSR_W-1:0]   lfsr_shift;

   assign cmd_pop = cmd_valid && (!valid_ff || rsp_ready);

   // reload period per channel, zero tone period counts as one
   always_comb begin
      for (int i = 0; i < NUM_TONES; i++) begin
         eff_period[i] = (period_ff[i] == '0) ? PERIOD_W'(1) : period_ff[i];
      end
      case (rate_ff)
         2'd0:    eff_period[NUM_CH-1] = NOISE_P_RATE0;
         2'd1:    eff_period[NUM_CH-1] = NOISE_P_RATE1;
         2'd2:    eff_period[NUM_CH-1] = NOISE_P_RATE2;
         default: eff_period[NUM_CH-1] = eff_period[NUM_TONES-1];
      endcase
      for (int i = 0; i < NUM_CH; i++) begin
         reload[i] = (cnt_ff[i] <= CNT_W'(1));
      end
   end

   assign fb         = white_ff ? ^(lfsr_ff & taps_ff) : lfsr_ff[0];
   assign lfsr_shift = {fb, lfsr_ff[LFSR_W-1:1]};

   always_comb begin
      period_in = period_ff;
      atten_in  = atten_ff;
      stereo_in = stereo_ff;
      cnt_in    = cnt_ff;
      phase_in  = phase_ff;
      held_in   = held_ff;
      lfsr_in   = lfsr_ff;
      rate_in   = rate_ff;
      white_in  = white_ff;
      latch_in  = latch_ff;
      valid_in  = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (cmd_pop) begin
         valid_in = 1'b1;
         case (cmd.op)
            OP_TICK: begin
               for (int i = 0; i < NUM_CH; i++) begin
                  if (reload[i]) begin
                     cnt_in[i]   = {eff_period[i], 4'b0000} - CNT_W'(1)
                                   + {{(CNT_W-1){1'b0}}, cnt_ff[i][0]};
                     phase_in[i] = !phase_ff[i];
                  end else begin
                     cnt_in[i] = cnt_ff[i] - CNT_W'(1);
                  end
               end
               for (int i = 0; i < NUM_TONES; i++) begin
                  if (reload[i]) begin
                     held_in[i] = mix_level(atten_ff[i], stereo_ff[i], !phase_ff[i]);
                  end
               end
               // noise shifts only when its phase turns active
               if (reload[NUM_CH-1] && !phase_ff[NUM_CH-1]) begin
                  lfsr_in = lfsr_shift;
                  held_in[NUM_CH-1] = mix_level(atten_ff[NUM_CH-1], stereo_ff[NUM_CH-1],
                                                lfsr_shift[0]);
               end
            end
            OP_PERIOD_LO: begin
               latch_in = cmd.chan;
               if (cmd.chan < 2'(NUM_TONES)) begin
                  period_in[cmd.chan] = {period_ff[cmd.chan][PERIOD_W-1:4], cmd.data[3:0]};
               end
            end
            OP_PERIOD_HI: begin
               if (latch_ff < 2'(NUM_TONES)) begin
                  period_in[latch_ff] = {cmd.data[5:0], period_ff[latch_ff][3:0]};
               end
            end
            OP_ATTEN: begin
               atten_in[cmd.chan] = cmd.data[3:0];
            end
            OP_NOISE_CTRL: begin
               rate_in  = cmd.data[1:0];
               white_in = cmd.data[2];
               lfsr_in  = LFSR_SEED;
            end
            OP_STEREO: begin
               for (int i = 0; i < NUM_CH; i++) begin
                  stereo_in[i] = {cmd.data[4+i], cmd.data[i]};
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff  <= TAPS_RESET;
         lfsr_ff  <= LFSR_SEED;
         rate_ff  <= '0;
         white_ff <= 1'b1;
         latch_ff <= '0;
         valid_ff <= 1'b0;
         for (int i = 0; i < NUM_TONES; i++) begin
            period_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_CH; i++) begin
            atten_ff[i]  <= ATTEN_SILENT;
            stereo_ff[i] <= 2'b11;
            cnt_ff[i]    <= '0;
            phase_ff[i]  <= 1'b1;
            held_ff[i]   <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            taps_ff <= csr_wr_data;
         end
         lfsr_ff   <= lfsr_in;
         rate_ff   <= rate_in;
         white_ff  <= white_in;
         latch_ff  <= latch_in;
         valid_ff  <= valid_in;
         period_ff <= period_in;
         atten_ff  <= atten_in;
         stereo_ff <= stereo_in;
         cnt_ff    <= cnt_in;
         phase_ff  <= phase_in;
         held_ff   <= held_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign level     = held_ff;

endmodule

### design/psg_tone_noise_generator.sv
// channel   | handshake            | word contents
// req_      | tvalid/tready        | tuser: mode; tdata: address, data
// rsp_      | tvalid/tready        | tdata: tone1, tone2, tone3, noise levels
// csr_      | wr_en, no wait       | wr_data: lfsr feedback tap mask
//
// one word per cycle sustained while responses are taken; a request is answered
// after it passes the two-entry queue and the engine writes its response register.
// every command executes when it is popped; the response register is the
// held-level state, so it only advances once any pending response is taken.
// reset is synchronous and restores all chip registers, counters and the lfsr.
// a stalled response backs up into the queue, then deasserts req_tready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psg_tone_noise_generator
   import psgt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] address, [15:8] data
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [10:0] tone1, [21:11] tone2, [32:22] tone3,
                                    // [43:33] noise, [47:44] zero
);

   cmd_type            dec_cmd;
   cmd_type            head_cmd;
   queue_status_type   q_stat;
   logic               q_push;
   logic               q_pop;
   logic [LEVEL_W-1:0] level [NUM_CH];

   psgt_decode u_decode (
      .mode    (req_tuser),
      .address (req_tdata[7:0]),
      .data    (req_tdata[15:8]),
      .cmd     (dec_cmd)
   );

   assign req_tready = !q_stat.full;
   assign q_push     = req_tvalid && req_tready;

   psgt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (dec_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_stat)
   );

   psgt_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (!q_stat.empty),
      .cmd         (head_cmd),
      .cmd_pop     (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .level       (level)
   );

   assign rsp_tdata = {4'b0000, level[3], level[2], level[1], level[0]};

   `PSG_ASSERT_IMP(a_pop_nonempty, clock, reset, q_pop, !q_stat.empty, "pop from empty queue")
   `PSG_ASSERT_NXT(a_pop_gives_rsp, clock, reset, q_pop, rsp_tvalid, "executed word without response")
   `PSG_ASSERT_NXT(a_queue_count, clock, reset, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1, "queue count lost a push")
   `PSG_ASSERT_IMP(a_level_range, clock, reset, rsp_tvalid, level[0] <= LEVEL_MAX && level[1] <= LEVEL_MAX && level[2] <= LEVEL_MAX && level[3] <= LEVEL_MAX, "level out of range")

endmodule

### bench/testbench.sv
// self-checking bench for psg_tone_noise_generator: directed rows, then random phases
// drives the req_/rsp_/csr_ stream ports and tracks the chip state in a local predictor
// depends on psgt_pkg and the top level only
`timescale 1ns / 1ps

module testbench
   import psgt_pkg::*;
();

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   localparam logic [7:0] ADDR_TONE1_LO    = 8'h00;
   localparam logic [7:0] ADDR_ATTEN1      = 8'h01;
   localparam logic [7:0] ADDR_TONE2_LO    = 8'h02;
   localparam logic [7:0] ADDR_ATTEN2      = 8'h03;
   localparam logic [7:0] ADDR_TONE3_LO    = 8'h04;
   localparam logic [7:0] ADDR_ATTEN3      = 8'h05;
   localparam logic [7:0] ADDR_ATTEN_NOISE = 8'h07;
   localparam logic [7:0] ADDR_UNUSED_HIGH = 8'hFF;
   localparam logic [7:0] ATTEN_ADDRS [4]  =
      '{ADDR_ATTEN1, ADDR_ATTEN2, ADDR_ATTEN3, ADDR_ATTEN_NOISE};

   localparam int TONE3    = 2;
   localparam int NOISE_CH = 3;

   localparam logic [1:0] RATE_FROM_TONE3 = 2'd3;
   localparam logic [PERIOD_W-1:0] NOISE_FIXED_PER [3] =
      '{NOISE_P_RATE0, NOISE_P_RATE1, NOISE_P_RATE2};

   localparam int ATTEN_LEVELS [16] = '{1516, 1205, 957, 760, 603, 479, 381, 303,
                                       240, 191, 152, 120, 96, 76, 60, 0};

   localparam int SEND_IDLE  [4] = '{0, 69, 0, 29};
   localparam int RECV_STALL [4] = '{0, 0, 69, 29};

   typedef struct packed {
      logic [LEVEL_W-1:0] noise;
      logic [LEVEL_W-1:0] tone3;
      logic [LEVEL_W-1:0] tone2;
      logic [LEVEL_W-1:0] tone1;
   } levels_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] address;
      logic [7:0] data;
   } req_word_type;

   typedef struct packed {
      logic       known;
      logic       mode;
      logic [7:0] address;
      logic [7:0] data;
      levels_type lv;
   } dir_row_type;

   localparam levels_type SILENT = '0;
   localparam int NUM_DIR = 26;

   // writes leave the held levels alone, and the first tick only drops every phase
   localparam dir_row_type DIR_ROWS [NUM_DIR] = '{
      '{1'b1, MODE_WRITE, ADDR_ATTEN1,      8'h00, SILENT},
      '{1'b1, MODE_WRITE, ADDR_ATTEN2,      8'hF0, SILENT},
      '{1'b1, MODE_WRITE, ADDR_ATTEN_NOISE, 8'h00, SILENT},
      '{1'b1, MODE_WRITE, ADDR_TONE1_LO,    8'hFF, SILENT},
      '{1'b1, MODE_WRITE, ADDR_PERIOD_HI,   8'hFF, SILENT},
      '{1'b1, MODE_WRITE, ADDR_TONE2_LO,    8'h00, SILENT},
      '{1'b1, MODE_WRITE, ADDR_PERIOD_HI,   8'hC0, SILENT},
      '{1'b1, MODE_WRITE, ADDR_UNUSED_HIGH, 8'hFF, SILENT},
      '{1'b1, MODE_WRITE, ADDR_STEREO,      8'h9B, SILENT},
      '{1'b1, MODE_WRITE, ADDR_NOISE_CTRL,  8'hFB, SILENT},
      '{1'b1, MODE_TICK,  8'hFF,            8'hFF, SILENT},
      '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT}, '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT},
      '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT}, '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT},
      '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT}, '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT},
      '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT}, '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT},
      '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT}, '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT},
      '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT}, '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT},
      '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT}, '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT},
      '{1'b0, MODE_TICK,  8'h00, 8'h00, SILENT}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int fail_count = 0;

   levels_type pending_levels [$];

   // predicted chip state
   logic [PERIOD_W-1:0] per_reg   [NUM_TONES];
   logic [3:0]          atten_reg [NUM_CH];
   logic [1:0]          pan_reg   [NUM_CH];
   logic [CNT_W-1:0]    cnt_reg   [NUM_CH];
   logic                flip_reg  [NUM_CH];
   logic [LEVEL_W-1:0]  held_reg  [NUM_CH];
   logic [LFSR_W-1:0]   lfsr_reg;
   logic [LFSR_W-1:0]   taps_reg;
   logic [1:0]          rate_reg;
   logic                white_reg;
   logic [1:0]          latch_reg;

   psg_tone_noise_generator dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void reset_chip();
      for (int ch = 0; ch < NUM_CH; ch++) begin
         if (ch < NUM_TONES) per_reg[ch] = '0;
         atten_reg[ch] = ATTEN_SILENT;
         pan_reg[ch]   = 2'b11;
         cnt_reg[ch]   = '0;
         flip_reg[ch]  = 1'b1;
         held_reg[ch]  = '0;
      end
      lfsr_reg  = LFSR_SEED;
      taps_reg  = TAPS_RESET;
      rate_reg  = '0;
      white_reg = 1'b1;
      latch_reg = '0;
   endfunction

   function automatic logic [LEVEL_W-1:0] side_average(input int ch, input logic on);
      logic [LEVEL_W:0] v;
      logic [LEVEL_W:0] l;
      logic [LEVEL_W:0] r;
      v = on ? (LEVEL_W+1)'(ATTEN_LEVELS[atten_reg[ch]]) : '0;
      l = pan_reg[ch][1] ? v : '0;
      r = pan_reg[ch][0] ? v : '0;
      return LEVEL_W'((l + r) >> 1);
   endfunction

   function automatic logic [PERIOD_W-1:0] tone_eff_period(input int ch);
      return (per_reg[ch] == '0) ? PERIOD_W'(1) : per_reg[ch];
   endfunction

   // one tick of a down counter, returns 1 on reload
   function automatic logic count_reload(input int ch, input logic [PERIOD_W-1:0] per);
      if (cnt_reg[ch] <= CNT_W'(1)) begin
         cnt_reg[ch]  = {per, 4'b0000} - CNT_W'(1) + cnt_reg[ch];
         flip_reg[ch] = ~flip_reg[ch];
         return 1'b1;
      end
      cnt_reg[ch] = cnt_reg[ch] - CNT_W'(1);
      return 1'b0;
   endfunction

   function automatic void tick_chip();
      logic [PERIOD_W-1:0] per;
      logic                fb;
      logic                reloaded;
      for (int ch = 0; ch < NUM_TONES; ch++) begin
         if (count_reload(ch, tone_eff_period(ch)))
            held_reg[ch] = side_average(ch, flip_reg[ch]);
      end
      per = (rate_reg == RATE_FROM_TONE3) ? tone_eff_period(TONE3)
                                          : NOISE_FIXED_PER[rate_reg];
      reloaded = count_reload(NOISE_CH, per);
      // noise shifts only on the reload that makes its phase active
      if (reloaded && flip_reg[NOISE_CH]) begin
         fb = white_reg ? ^(lfsr_reg & taps_reg) : lfsr_reg[0];
         lfsr_reg = {fb, lfsr_reg[LFSR_W-1:1]};
         held_reg[NOISE_CH] = side_average(NOISE_CH, lfsr_reg[0]);
      end
   endfunction

   function automatic void write_chip(input logic [7:0] address, input logic [7:0] data);
      case (address)
         ADDR_TONE1_LO, ADDR_TONE2_LO, ADDR_TONE3_LO: begin
            latch_reg = address[2:1];
            per_reg[latch_reg][3:0] = data[3:0];
         end
         ADDR_ATTEN1, ADDR_ATTEN2, ADDR_ATTEN3, ADDR_ATTEN_NOISE:
            atten_reg[address[2:1]] = data[3:0];
         ADDR_NOISE_CTRL: begin
            rate_reg  = data[1:0];
            white_reg = data[2];
            lfsr_reg  = LFSR_SEED;
         end
         ADDR_STEREO:
            for (int ch = 0; ch < NUM_CH; ch++) pan_reg[ch] = {data[4+ch], data[ch]};
         ADDR_PERIOD_HI:
            if (latch_reg < NUM_TONES) per_reg[latch_reg][9:4] = data[5:0];
         default: ;
      endcase
   endfunction

   function automatic levels_type chip_step(input req_word_type w);
      levels_type lv;
      if (w.mode == MODE_TICK) tick_chip();
      else write_chip(w.address, w.data);
      lv.tone1 = held_reg[0];
      lv.tone2 = held_reg[1];
      lv.tone3 = held_reg[2];
      lv.noise = held_reg[NOISE_CH];
      return lv;
   endfunction

   // mostly ticks with short periods, so counters reload and the noise shifts often
   function automatic req_word_type random_word();
      req_word_type w;
      w.mode    = MODE_TICK;
      w.address = 8'($urandom);
      w.data    = 8'($urandom);
      if ($urandom_range(99) < 35) begin
         w.mode = MODE_WRITE;
         case ($urandom_range(9))
            0, 1, 2: begin
               w.address = (w.address[1:0] == 2'd0) ? ADDR_TONE1_LO :
                           (w.address[1:0] == 2'd1) ? ADDR_TONE2_LO : ADDR_TONE3_LO;
               if ($urandom_range(1) == 0) w.data[3:0] = 4'($urandom_range(2));
            end
            3, 4: begin
               w.address = ADDR_PERIOD_HI;
               if ($urandom_range(99) < 85) w.data[5:0] = '0;
            end
            5, 8: w.address = ATTEN_ADDRS[2'($urandom_range(3))];
            6: begin
               w.address = ADDR_NOISE_CTRL;
               if ($urandom_range(3) != 0) w.data[1:0] = RATE_FROM_TONE3;
            end
            7: w.address = ADDR_STEREO;
            default: ;
         endcase
      end
      return w;
   endfunction

   task automatic send_word(input req_word_type w, input logic known,
                            input levels_type known_lv);
      levels_type want;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.mode;
      req_tdata  <= {w.data, w.address};
      do @(posedge clock); while (!req_tready);
      want = chip_step(w);
      pending_levels.push_back(known ? known_lv : want);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_taps(input logic [15:0] taps);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= taps;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      taps_reg = taps;
   endtask

   function automatic void check_level(input string name, input logic [LEVEL_W-1:0] want,
                                       input logic [LEVEL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s level expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // receiver: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      levels_type got;
      levels_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[43:0];
         if (pending_levels.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
            fail_count++;
         end else begin
            want = pending_levels.pop_front();
            check_level("tone1", want.tone1, got.tone1);
            check_level("tone2", want.tone2, got.tone2);
            check_level("tone3", want.tone3, got.tone3);
            check_level("noise", want.noise, got.noise);
         end
      end
   end

   initial begin
      req_word_type w;
      logic [15:0] taps;
      reset_chip();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (DIR_ROWS[i]) begin
         w.mode    = DIR_ROWS[i].mode;
         w.address = DIR_ROWS[i].address;
         w.data    = DIR_ROWS[i].data;
         send_word(w, DIR_ROWS[i].known, DIR_ROWS[i].lv);
      end
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = SEND_IDLE[phase];
         recv_stall_pct = RECV_STALL[phase];
         case (phase)
            0: taps = 16'h0000;
            1: taps = 16'hFFFF;
            2: taps = 16'($urandom);
            default: taps = TAPS_RESET;
         endcase
         write_taps(taps);
         repeat (90) send_word(random_word(), 1'b0, SILENT);
         wait_idle();
      end

      // long receiver hold-off while the sender keeps pushing words
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_taps(16'h6000);
      hold_cycles = 60;
      repeat (40) send_word(random_word(), 1'b0, SILENT);
      wait_idle();

      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
